[rtl/assert_macros.svh]
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

`endif

[rtl/ogn_pkg.sv]
package ogn_pkg;

    // Default parameter values
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int MAX_OCTAVE_EXP_DEF  = 15;

    // Fixed field widths
    localparam int COORD_W   = 16;
    localparam int AMP_W     = 16;
    localparam int EXP_W     = 4;
    localparam int NOISE_W   = 28;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier
    localparam int OP_W   = 32;
    localparam int PROD_W = 2 * OP_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_AMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP  = 2'd2;

    // Register reset values
    localparam logic [AMP_W-1:0] AMP_RST     = 16'd256;
    localparam logic [EXP_W-1:0] MIN_EXP_RST = 4'd0;
    localparam logic [EXP_W-1:0] MAX_EXP_RST = 4'd4;

    // Multiply request from the sequencer
    typedef struct packed {
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } mul_req_t;

    // Control into the core
    typedef struct packed {
        logic start;
        logic res_ready;
    } core_ctl_t;

    // Status out of the core
    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_sts_t;

endpackage

[rtl/ogn_mul.sv]
module ogn_mul
(
    input  logic                                clk,
    input  ogn_pkg::mul_req_t                   req,
    output logic signed [ogn_pkg::PROD_W-1:0]   prod
);

    logic signed [ogn_pkg::PROD_W-1:0] prod_reg;

    // Multiply and register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= ogn_pkg::PROD_W'(req.a * req.b);
    end

    assign prod = prod_reg;

endmodule

[rtl/ogn_core.sv]
module ogn_core
#(
    parameter int COORD_FRAC_BITS = ogn_pkg::COORD_FRAC_BITS_DEF,
    parameter int MAX_OCTAVE_EXP  = ogn_pkg::MAX_OCTAVE_EXP_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ogn_pkg::core_ctl_t                    ctl,
    output ogn_pkg::core_sts_t                    sts,
    input  logic [ogn_pkg::COORD_W-1:0]           coord_u,
    input  logic [ogn_pkg::COORD_W-1:0]           coord_v,
    input  logic [ogn_pkg::AMP_W-1:0]             amp,
    input  logic [ogn_pkg::EXP_W-1:0]             lo_exp,
    input  logic [ogn_pkg::EXP_W-1:0]             hi_exp,
    output ogn_pkg::mul_req_t                     req,
    input  logic signed [ogn_pkg::PROD_W-1:0]     prod,
    output logic signed [ogn_pkg::NOISE_W-1:0]    noise
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int KMAX  = (MAX_OCTAVE_EXP < 15) ? MAX_OCTAVE_EXP : 15;
    localparam int IDX_W = KMAX + 1;
    localparam int P_W   = F + KMAX;
    localparam int T_W   = F + 1;
    localparam int DOT_W = 20;
    localparam int SUM_W = 32;
    localparam int OP_W  = ogn_pkg::OP_W;
    localparam int PR_W  = ogn_pkg::PROD_W;

    localparam logic [OP_W-1:0] ONE_OP   = OP_W'(1) << F;
    localparam logic [OP_W-1:0] THREE_OP = OP_W'(3) << F;
    localparam logic signed [PR_W-1:0] HALF_F = PR_W'(1) <<< (F - 1);
    localparam logic signed [PR_W-1:0] HALF_D = PR_W'(1) <<< (F - 2);

    localparam logic [31:0] PMOD    = 32'h7fffffff;
    localparam logic [OP_W-1:0] PM_MUL   = OP_W'(48271);
    localparam logic [OP_W-1:0] HASH_X   = 32'h0badf00d;
    localparam logic [OP_W-1:0] HASH_Y   = 32'h13371337;
    localparam logic [31:0]     HASH_F   = 32'hdeadbeef;

    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(134217727);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(134217728);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_SM1   = 4'd2;
    localparam logic [3:0] S_SM2   = 4'd3;
    localparam logic [3:0] S_HX    = 4'd4;
    localparam logic [3:0] S_HY    = 4'd5;
    localparam logic [3:0] S_FOLD  = 4'd6;
    localparam logic [3:0] S_PM1   = 4'd7;
    localparam logic [3:0] S_PM2   = 4'd8;
    localparam logic [3:0] S_DX    = 4'd9;
    localparam logic [3:0] S_DY    = 4'd10;
    localparam logic [3:0] S_B1    = 4'd11;
    localparam logic [3:0] S_B2    = 4'd12;
    localparam logic [3:0] S_AMP   = 4'd13;
    localparam logic [3:0] S_ACC   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    // Map one generator draw to Q1.15, round half away from zero
    function automatic logic signed [15:0] draw_q15(input logic [31:0] g);
        logic signed [32:0] s;
        logic               neg;
        logic [29:0]        b;
        logic [46:0]        x;
        logic [15:0]        q0;
        logic [31:0]        r;
        logic [16:0]        q;
        s   = $signed({1'b0, g}) - 33'sd1073741824;
        neg = s[32];
        b   = neg ? 30'(-s) : 30'(s);
        x   = 47'({b, 16'b0}) + 47'(30'h3fffffff);
        q0  = x[46:31];
        r   = {1'b0, x[30:0]} + {15'b0, q0, 1'b0};
        q   = {1'b0, q0} + ((r >= 32'h7ffffffe) ? 17'd1 : 17'd0);
        if (neg)
        begin
            return 16'(17'd0 - q);
        end
        return (q > 17'd32767) ? 16'sd32767 : 16'(q);
    endfunction

    // Reduce a hash modulo 2^31-1, zero becomes one
    function automatic logic [31:0] fold_hash(input logic [31:0] h);
        logic [31:0] t;
        t = {1'b0, h[30:0]} + 32'(h[31]);
        if (t >= PMOD)
        begin
            t = t - PMOD;
        end
        return (t == 32'd0) ? 32'd1 : t;
    endfunction

    // Reduce a generator product modulo 2^31-1
    function automatic logic [31:0] fold_prod(input logic [PR_W-1:0] p);
        logic [31:0] t;
        t = 32'(p[30:0]) + 32'(p[46:31]);
        if (t >= PMOD)
        begin
            t = t - PMOD;
        end
        return t;
    endfunction

    logic [3:0]                 state_reg, state_next;
    logic                       phase_reg, phase_next;
    logic [1:0]                 sel_reg, sel_next;
    logic [ogn_pkg::EXP_W-1:0]  k_reg, k_next;
    logic [ogn_pkg::EXP_W-1:0]  i_reg, i_next;
    logic [F-1:0]               u_reg, u_next;
    logic [F-1:0]               v_reg, v_next;
    logic [F-1:0]               fx_reg, fx_next;
    logic [F-1:0]               fy_reg, fy_next;
    logic [KMAX-1:0]            x0_reg, x0_next;
    logic [KMAX-1:0]            y0_reg, y0_next;
    logic [T_W-1:0]             tmp_reg, tmp_next;
    logic [T_W-1:0]             sx_reg, sx_next;
    logic [T_W-1:0]             sy_reg, sy_next;
    logic [31:0]                hx_reg, hx_next;
    logic [31:0]                seed_reg, seed_next;
    logic signed [15:0]         gx_reg, gx_next;
    logic signed [15:0]         gy_reg, gy_next;
    logic signed [PR_W-1:0]     acc_reg, acc_next;
    logic signed [DOT_W-1:0]    dot_reg [4];
    logic signed [DOT_W-1:0]    dot_next [4];
    logic signed [SUM_W-1:0]    sum_reg, sum_next;

    logic [ogn_pkg::EXP_W-1:0]  hi_eff;
    logic [P_W-1:0]             px, py;
    logic [IDX_W-1:0]           freq;
    logic [IDX_W-1:0]           x1, y1;
    logic [KMAX-1:0]            cx, cy;
    logic [F-1:0]               t_cur;
    logic [OP_W-1:0]            dx_op, dy_op;
    logic [OP_W-1:0]            wsx_op, wsy_op;
    logic signed [PR_W-1:0]     pair_sum;
    logic [31:0]                u_wide, v_wide;

    // Clamp the top octave to what the lattice supports
    assign hi_eff = (hi_exp > ogn_pkg::EXP_W'(KMAX)) ? ogn_pkg::EXP_W'(KMAX) : hi_exp;

    // Lattice position and corner indexes
    assign px    = {{KMAX{1'b0}}, u_reg} << k_reg;
    assign py    = {{KMAX{1'b0}}, v_reg} << k_reg;
    assign freq  = IDX_W'(1) << k_reg;
    assign x1    = {1'b0, x0_reg} + IDX_W'(1);
    assign y1    = {1'b0, y0_reg} + IDX_W'(1);
    assign cx    = sel_reg[0] ? ((x1 == freq) ? '0 : x1[KMAX-1:0]) : x0_reg;
    assign cy    = sel_reg[1] ? ((y1 == freq) ? '0 : y1[KMAX-1:0]) : y0_reg;
    assign t_cur = sel_reg[0] ? fy_reg : fx_reg;

    // Offsets from the corner and blend weights
    assign dx_op  = OP_W'(fx_reg) - (sel_reg[0] ? ONE_OP : '0);
    assign dy_op  = OP_W'(fy_reg) - (sel_reg[1] ? ONE_OP : '0);
    assign wsx_op = OP_W'(sx_reg);
    assign wsy_op = OP_W'(sy_reg);

    assign pair_sum = acc_reg + prod;
    assign u_wide   = {16'b0, coord_u};
    assign v_wide   = {16'b0, coord_v};

    // Select multiplier operands for the current step
    always_comb
    begin
        req = '0;
        case (state_reg)
            S_SM1:
            begin
                req.a = OP_W'(t_cur);
                req.b = OP_W'(t_cur);
            end
            S_SM2:
            begin
                req.a = OP_W'(tmp_reg);
                req.b = THREE_OP - (OP_W'(t_cur) << 1);
            end
            S_HX:
            begin
                req.a = HASH_X;
                req.b = OP_W'(cx);
            end
            S_HY:
            begin
                req.a = HASH_Y;
                req.b = OP_W'(cy);
            end
            S_PM1, S_PM2:
            begin
                req.a = seed_reg;
                req.b = PM_MUL;
            end
            S_DX:
            begin
                req.a = dx_op;
                req.b = OP_W'(gx_reg);
            end
            S_DY:
            begin
                req.a = dy_op;
                req.b = OP_W'(gy_reg);
            end
            S_B1:
            begin
                case (sel_reg)
                    2'd0:
                    begin
                        req.a = OP_W'(dot_reg[0]);
                        req.b = ONE_OP - wsx_op;
                    end
                    2'd1:
                    begin
                        req.a = OP_W'(dot_reg[2]);
                        req.b = ONE_OP - wsx_op;
                    end
                    default:
                    begin
                        req.a = OP_W'(dot_reg[0]);
                        req.b = ONE_OP - wsy_op;
                    end
                endcase
            end
            S_B2:
            begin
                case (sel_reg)
                    2'd0:
                    begin
                        req.a = OP_W'(dot_reg[1]);
                        req.b = wsx_op;
                    end
                    2'd1:
                    begin
                        req.a = OP_W'(dot_reg[3]);
                        req.b = wsx_op;
                    end
                    default:
                    begin
                        req.a = OP_W'(dot_reg[1]);
                        req.b = wsy_op;
                    end
                endcase
            end
            S_AMP:
            begin
                req.a = OP_W'(dot_reg[2]);
                req.b = OP_W'(amp);
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // Step the sequencer and write back results
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sel_next   = sel_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        tmp_next   = tmp_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        hx_next    = hx_reg;
        seed_next  = seed_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        acc_next   = acc_reg;
        sum_next   = sum_reg;
        for (int j = 0; j < 4; j++)
        begin
            dot_next[j] = dot_reg[j];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    u_next     = u_wide[F-1:0];
                    v_next     = v_wide[F-1:0];
                    k_next     = lo_exp;
                    i_next     = '0;
                    sum_next   = '0;
                    phase_next = 1'b0;
                    sel_next   = 2'd0;
                    state_next = (lo_exp > hi_eff) ? S_DONE : S_SETUP;
                end
            end
            S_SETUP:
            begin
                x0_next    = px[P_W-1:F];
                fx_next    = px[F-1:0];
                y0_next    = py[P_W-1:F];
                fy_next    = py[F-1:0];
                sel_next   = 2'd0;
                state_next = S_SM1;
            end
            S_FOLD:
            begin
                seed_next  = fold_hash(seed_reg);
                state_next = S_PM1;
            end
            S_ACC:
            begin
                sum_next = sum_reg
                    + SUM_W'(acc_reg >>> (5'd8 + 5'(i_reg)));
                if (k_reg == hi_eff)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_DONE:
            begin
                if (ctl.res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                // Multiply steps: issue, then write back
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    case (state_reg)
                        S_SM1:
                        begin
                            tmp_next   = T_W'((prod + HALF_F) >>> F);
                            state_next = S_SM2;
                        end
                        S_SM2:
                        begin
                            if (sel_reg[0])
                            begin
                                sy_next    = T_W'((prod + HALF_F) >>> F);
                                sel_next   = 2'd0;
                                state_next = S_HX;
                            end
                            else
                            begin
                                sx_next    = T_W'((prod + HALF_F) >>> F);
                                sel_next   = 2'd1;
                                state_next = S_SM1;
                            end
                        end
                        S_HX:
                        begin
                            hx_next    = prod[31:0] + (HASH_F << k_reg);
                            state_next = S_HY;
                        end
                        S_HY:
                        begin
                            seed_next  = hx_reg + prod[31:0];
                            state_next = S_FOLD;
                        end
                        S_PM1:
                        begin
                            seed_next  = fold_prod(prod);
                            state_next = S_PM2;
                        end
                        S_PM2:
                        begin
                            gx_next    = draw_q15(seed_reg);
                            seed_next  = fold_prod(prod);
                            state_next = S_DX;
                        end
                        S_DX:
                        begin
                            acc_next   = prod + HALF_D;
                            gy_next    = draw_q15(seed_reg);
                            state_next = S_DY;
                        end
                        S_DY:
                        begin
                            dot_next[sel_reg] = DOT_W'(pair_sum >>> (F - 1));
                            sel_next          = sel_reg + 2'd1;
                            state_next        = (sel_reg == 2'd3) ? S_B1 : S_HX;
                        end
                        S_B1:
                        begin
                            acc_next   = prod + HALF_F;
                            state_next = S_B2;
                        end
                        S_B2:
                        begin
                            case (sel_reg)
                                2'd0:
                                begin
                                    dot_next[0] = DOT_W'(pair_sum >>> F);
                                    sel_next    = 2'd1;
                                    state_next  = S_B1;
                                end
                                2'd1:
                                begin
                                    dot_next[1] = DOT_W'(pair_sum >>> F);
                                    sel_next    = 2'd2;
                                    state_next  = S_B1;
                                end
                                default:
                                begin
                                    dot_next[2] = DOT_W'(pair_sum >>> F);
                                    sel_next    = 2'd0;
                                    state_next  = S_AMP;
                                end
                            endcase
                        end
                        S_AMP:
                        begin
                            acc_next   = prod + (PR_W'(1) <<< (5'd7 + 5'(i_reg)));
                            state_next = S_ACC;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        i_reg    <= i_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        tmp_reg  <= tmp_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        hx_reg   <= hx_next;
        seed_reg <= seed_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        for (int j = 0; j < 4; j++)
        begin
            dot_reg[j] <= dot_next[j];
        end
    end

    // Saturate the octave sum
    always_comb
    begin
        if (sum_reg > OUT_MAX)
        begin
            noise = OUT_MAX[ogn_pkg::NOISE_W-1:0];
        end
        else if (sum_reg < OUT_MIN)
        begin
            noise = OUT_MIN[ogn_pkg::NOISE_W-1:0];
        end
        else
        begin
            noise = sum_reg[ogn_pkg::NOISE_W-1:0];
        end
    end

    assign sts.idle      = (state_reg == S_IDLE);
    assign sts.res_valid = (state_reg == S_DONE);

endmodule

[rtl/octave_gradient_noise.sv]
// Channel   Dir  Payload (low bit first)                  Handshake
// s_        in   coord_u[15:0], coord_v[31:16]             s_tvalid / s_tready
// m_        out  noise_value[27:0], zero pad [31:28]       m_tvalid / m_tready
// cfg_      in   cfg_index selects, cfg_data value         cfg_valid / cfg_ready
//
// Each octave in the range runs 35 steps through one shared 32x32 multiplier,
// each step issuing its operands and then writing back the product; an
// empty octave range goes straight to the result.
// Reset clears the sequencer and loads the register defaults; cfg_ready is
// always high. A finished result sits in the output register while the next
// texel is taken; the core holds its result until that register frees up.
module octave_gradient_noise
#(
    parameter int COORD_FRAC_BITS = ogn_pkg::COORD_FRAC_BITS_DEF,
    parameter int MAX_OCTAVE_EXP  = ogn_pkg::MAX_OCTAVE_EXP_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // coord_u, coord_v
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // noise_value, pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ogn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ogn_pkg::AMP_W-1:0]         cfg_data
);

    logic [ogn_pkg::AMP_W-1:0]            amp_reg, amp_next;
    logic [ogn_pkg::EXP_W-1:0]            lo_reg, lo_next;
    logic [ogn_pkg::EXP_W-1:0]            hi_reg, hi_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [ogn_pkg::NOISE_W-1:0]   out_data_reg, out_data_next;

    ogn_pkg::core_ctl_t                   ctl;
    ogn_pkg::core_sts_t                   sts;
    ogn_pkg::mul_req_t                    req;
    logic signed [ogn_pkg::PROD_W-1:0]    prod;
    logic signed [ogn_pkg::NOISE_W-1:0]   noise;

    assign cfg_ready = 1'b1;
    assign s_tready  = sts.idle;

    assign ctl.start     = s_tvalid & sts.idle;
    assign ctl.res_ready = ~out_valid_reg | m_tready;

    // Write configuration registers
    always_comb
    begin
        amp_next = amp_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ogn_pkg::CFG_BASE_AMP: amp_next = cfg_data;
                ogn_pkg::CFG_MIN_EXP:  lo_next  = cfg_data[ogn_pkg::EXP_W-1:0];
                ogn_pkg::CFG_MAX_EXP:  hi_next  = cfg_data[ogn_pkg::EXP_W-1:0];
                default:               amp_next = amp_reg;
            endcase
        end
    end

    // Load and drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (sts.res_valid && ctl.res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = noise;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg       <= ogn_pkg::AMP_RST;
            lo_reg        <= ogn_pkg::MIN_EXP_RST;
            hi_reg        <= ogn_pkg::MAX_EXP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            amp_reg       <= amp_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

    ogn_core
    #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .MAX_OCTAVE_EXP  (MAX_OCTAVE_EXP)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .sts     (sts),
        .coord_u (s_tdata[15:0]),
        .coord_v (s_tdata[31:16]),
        .amp     (amp_reg),
        .lo_exp  (lo_reg),
        .hi_exp  (hi_reg),
        .req     (req),
        .prod    (prod),
        .noise   (noise)
    );

    ogn_mul u_mul
    (
        .clk  (clk),
        .req  (req),
        .prod (prod)
    );

endmodule

[rtl/ogn_checker.sv]
`include "assert_macros.svh"

module ogn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A held result stays offered
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // A held result keeps its value
    `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // An accepted request keeps the input closed for the next cycle
    `ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

    // Padding above the noise value stays zero
    `ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[31:28] == 4'b0)

endmodule

bind octave_gradient_noise ogn_checker u_ogn_checker (.*);

[tb/sv/noise_checker.sv]
`timescale 1ns / 1ps

module noise_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [31:0]                   m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ogn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ogn_pkg::AMP_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending
);

    localparam int    FRAC      = ogn_pkg::COORD_FRAC_BITS_DEF;
    localparam int    TOP_EXP   = ogn_pkg::MAX_OCTAVE_EXP_DEF;
    localparam longint ONE      = longint'(1) <<< FRAC;
    localparam longint PM_MOD   = 64'd2147483647;
    localparam longint PM_MUL   = 64'd48271;
    localparam longint PM_SPAN  = 64'd2147483646;
    localparam longint SAT_MAX  = 64'd134217727;
    localparam longint SAT_MIN  = -64'sd134217728;

    // Shadow registers
    logic [ogn_pkg::AMP_W-1:0] amp_reg;
    logic [ogn_pkg::EXP_W-1:0] lo_exp_reg;
    logic [ogn_pkg::EXP_W-1:0] hi_exp_reg;

    logic [ogn_pkg::NOISE_W-1:0] noise_fifo[$];

    // Floor of (v + half) / 2^sh
    function automatic longint round_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint draw_q15(longint g);
        longint n;
        longint a;
        longint q;
        n = 2 * (g - 1) - PM_SPAN;
        a = (n < 0) ? -n : n;
        q = (a * 32768 + PM_SPAN / 2) / PM_SPAN;
        if (n < 0)
            q = -q;
        if (q > 32767)
            q = 32767;
        return q;
    endfunction

    function automatic longint corner_dot(bit [31:0] freq, bit [31:0] x, bit [31:0] y,
                                          longint dx, longint dy);
        bit [31:0] h;
        longint    s;
        longint    gx;
        longint    gy;
        // Wrap the far lattice edge so the pattern tiles
        if (x == freq)
            x = 0;
        if (y == freq)
            y = 0;
        h = 32'hdeadbeef * freq + 32'h0badf00d * x + 32'h13371337 * y;
        s = longint'(h) % PM_MOD;
        if (s == 0)
            s = 1;
        s  = (s * PM_MUL) % PM_MOD;
        gx = draw_q15(s);
        s  = (s * PM_MUL) % PM_MOD;
        gy = draw_q15(s);
        return round_shift(dx * gx + dy * gy, FRAC - 1);
    endfunction

    function automatic longint smoothstep(longint t);
        longint t2;
        t2 = round_shift(t * t, FRAC);
        return round_shift(t2 * (3 * ONE - 2 * t), FRAC);
    endfunction

    function automatic longint octave_noise(longint u, longint v, int k);
        bit [31:0] freq;
        bit [31:0] x0;
        bit [31:0] y0;
        longint    px;
        longint    py;
        longint    fx;
        longint    fy;
        longint    sx;
        longint    sy;
        longint    sw;
        longint    se;
        longint    nw;
        longint    ne;
        longint    south;
        longint    north;
        freq = 32'd1 << k;
        px = u <<< k;
        py = v <<< k;
        x0 = 32'(px >>> FRAC);
        y0 = 32'(py >>> FRAC);
        fx = px & (ONE - 1);
        fy = py & (ONE - 1);
        sx = smoothstep(fx);
        sy = smoothstep(fy);
        sw = corner_dot(freq, x0, y0, fx, fy);
        se = corner_dot(freq, x0 + 1, y0, fx - ONE, fy);
        nw = corner_dot(freq, x0, y0 + 1, fx, fy - ONE);
        ne = corner_dot(freq, x0 + 1, y0 + 1, fx - ONE, fy - ONE);
        south = round_shift(sw * (ONE - sx) + se * sx, FRAC);
        north = round_shift(nw * (ONE - sx) + ne * sx, FRAC);
        return round_shift(south * (ONE - sy) + north * sy, FRAC);
    endfunction

    function automatic logic [ogn_pkg::NOISE_W-1:0] texel_noise(
        logic [ogn_pkg::COORD_W-1:0] u, logic [ogn_pkg::COORD_W-1:0] v);
        int     lo;
        int     hi;
        longint sum;
        lo  = int'(lo_exp_reg);
        hi  = int'(hi_exp_reg);
        sum = 0;
        // Drop octaves past the top exponent; an empty range sums to zero
        if (hi > TOP_EXP)
            hi = TOP_EXP;
        for (int k = lo; k <= hi; k++)
            sum += round_shift(octave_noise(u, v, k) * longint'(amp_reg), 8 + k - lo);
        if (sum > SAT_MAX)
            sum = SAT_MAX;
        if (sum < SAT_MIN)
            sum = SAT_MIN;
        return sum[ogn_pkg::NOISE_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
        fail_count++;
    endtask

    // Track register writes, predict on each request, check each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg    <= ogn_pkg::AMP_RST;
            lo_exp_reg <= ogn_pkg::MIN_EXP_RST;
            hi_exp_reg <= ogn_pkg::MAX_EXP_RST;
            fail_count = 0;
            noise_fifo.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ogn_pkg::CFG_BASE_AMP: amp_reg    <= cfg_data;
                    ogn_pkg::CFG_MIN_EXP:  lo_exp_reg <= cfg_data[ogn_pkg::EXP_W-1:0];
                    ogn_pkg::CFG_MAX_EXP:  hi_exp_reg <= cfg_data[ogn_pkg::EXP_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                noise_fifo.push_back(texel_noise(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                if (noise_fifo.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 32'd0);
                else
                begin
                    logic [ogn_pkg::NOISE_W-1:0] want;
                    want = noise_fifo.pop_front();
                    if (m_tdata[ogn_pkg::NOISE_W-1:0] !== want)
                        report_mismatch("noise_value",
                                        {4'd0, m_tdata[ogn_pkg::NOISE_W-1:0]},
                                        {4'd0, want});
                end
            end
            pending = noise_fifo.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam logic [ogn_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 200;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [31:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ogn_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ogn_pkg::AMP_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;

    bit  send_gaps;
    bit  recv_stalls;
    int  gap_pct;
    logic texel_taken;
    logic cfg_taken;
    int  quiet_cycles;

    octave_gradient_noise uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    noise_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Latch handshakes at the edge for the negedge-driven tasks
    always @(posedge clk)
    begin
        texel_taken <= s_tvalid && s_tready;
        cfg_taken   <= cfg_valid && cfg_ready;
    end

    // Random backpressure on results
    always @(negedge clk)
    begin
        if (recv_stalls)
            m_tready <= ($urandom_range(99) >= gap_pct);
        else
            m_tready <= 1'b1;
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_texel(logic [15:0] u, logic [15:0] v);
        if (send_gaps && ($urandom_range(99) < gap_pct))
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u};
        do
            @(negedge clk);
        while (!texel_taken);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [ogn_pkg::CFG_IDX_W-1:0] idx,
                             logic [ogn_pkg::AMP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
    endtask

    // Reprogram only once every result is out
    task automatic program_octaves(logic [ogn_pkg::AMP_W-1:0] amp,
                                   logic [ogn_pkg::EXP_W-1:0] lo,
                                   logic [ogn_pkg::EXP_W-1:0] hi);
        wait_drained();
        write_reg(ogn_pkg::CFG_BASE_AMP, amp);
        write_reg(ogn_pkg::CFG_MIN_EXP, {12'd0, lo});
        write_reg(ogn_pkg::CFG_MAX_EXP, {12'd0, hi});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h1 << $urandom_range(15);
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    initial
    begin
        logic [15:0] corner_u[8] = '{16'h0000, 16'hffff, 16'h0000, 16'hffff,
                                     16'h8000, 16'h0001, 16'h7fff, 16'h5555};
        logic [15:0] corner_v[8] = '{16'h0000, 16'hffff, 16'hffff, 16'h0000,
                                     16'h8000, 16'h0001, 16'h8001, 16'haaaa};
        int lo;
        int hi;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = ogn_pkg::CFG_BASE_AMP;
        cfg_data    = '0;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        gap_pct     = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Coordinate extremes at the reset settings
        for (int i = 0; i < 8; i++)
            send_texel(corner_u[i], corner_v[i]);

        // Full octave span at largest amplitude
        program_octaves(16'hffff, 4'd0, 4'd15);
        send_texel(16'hffff, 16'hffff);
        send_texel(16'h0000, 16'h0000);
        send_texel(16'h3c71, 16'hc38e);

        // Zero amplitude
        program_octaves(16'h0000, 4'd3, 4'd3);
        send_texel(16'h1234, 16'hfedc);
        send_texel(16'hffff, 16'h0001);

        // Empty range, plus a write to an unused index
        program_octaves(16'd300, 4'd9, 4'd2);
        @(negedge clk);
        write_reg(CFG_UNUSED, 16'hffff);
        cfg_valid <= 1'b0;
        send_texel(16'h4321, 16'h8765);
        send_texel(16'hffff, 16'hffff);

        // Only the top octave
        program_octaves(16'hffff, 4'd15, 4'd15);
        send_texel(16'hffff, 16'h0000);
        send_texel(16'h0001, 16'hfffe);
        send_texel(16'h9abc, 16'h2468);

        program_octaves(16'h0001, 4'd14, 4'd15);
        send_texel(16'h7777, 16'h8888);
        send_texel(16'hffff, 16'hffff);

        // Random phases, rotating through idle patterns
        for (int p = 0; p < 16; p++)
        begin
            lo = $urandom_range(15);
            hi = (p % 7 == 6) ? $urandom_range(15) : lo + $urandom_range(3);
            if (hi > 15)
                hi = 15;
            program_octaves((p == 0) ? 16'hffff : (p == 1) ? 16'h0000 :
                            ogn_pkg::AMP_W'($urandom_range(16'hffff)),
                            lo[3:0], hi[3:0]);
            send_gaps   = (p % 4 == 1) || (p % 4 == 3);
            recv_stalls = (p % 4 == 2) || (p % 4 == 3);
            gap_pct     = (p % 4 == 3) ? 15 : 63;
            for (int i = 0; i < 100; i++)
            begin
                // Hold off until the pipe is empty once mid-phase
                if (p == 5 && i == 50)
                    wait_drained();
                send_texel(rand_coord(), rand_coord());
            end
        end

        wait_drained();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
